[hdl/btm_pkg.sv]
// ----------------------------------------------------------------------------
// btm_pkg: shared types and constants
// Item, result and queue entry types plus register indexes for the
// 3x3 binary template matcher.
// ----------------------------------------------------------------------------
package btm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMPLATE = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [8:0] TEMPLATE_RESET = 9'd0;
  localparam logic [6:0] WIDTH_RESET    = 7'd10;
  localparam logic [6:0] HEIGHT_RESET   = 7'd10;

  localparam logic [6:0] MIN_SIZE   = 7'd3;
  localparam logic [6:0] MAX_HEIGHT = 7'd64;

  // window bits that survive the one-column shift
  localparam logic [8:0] ROW_MASK = 9'h0DB;

  // queue between front and back
  localparam int            QUEUE_DEPTH = 4;
  localparam int            QPTR_W      = 2;
  localparam logic [QPTR_W:0] QUEUE_FULL = 3'd4;

  typedef struct packed {
    logic pixel;
    logic frame_end;
  } item_t;

  typedef struct packed {
    logic [3:0] match_count;
    logic [5:0] best_column;
    logic [5:0] best_row;
    logic [8:0] best_window;
  } result_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [8:0] window;
    logic [5:0] column;
    logic [5:0] row;
    logic       eligible;
    logic       first;
    logic       frame_end;
  } work_t;

  function automatic logic [3:0] ones9(input logic [8:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 9; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage

[hdl/btm_queue.sv]
// ----------------------------------------------------------------------------
// btm_queue: work queue
// Short first-in first-out queue of classified pixels between the front
// and the back.
// ----------------------------------------------------------------------------
module btm_queue
  import btm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  work_t           push_data,
  input  logic            pop,
  output work_t           head,
  output logic            not_empty,
  output logic [QPTR_W:0] count
);

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end
  end

endmodule

[hdl/btm_front.sv]
// ----------------------------------------------------------------------------
// btm_front: raster front end
// Accepts pixels, tracks column and row, keeps the two line stores and
// the 3x3 window, and queues each pixel with its classification.
// ----------------------------------------------------------------------------
module btm_front
  import btm_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [6:0]      width,
  input  logic [6:0]      height,
  input  item_t           item,
  input  logic            item_valid,
  output logic            item_ready,
  input  logic [QPTR_W:0] q_count,
  output logic            push,
  output work_t           push_data
);

  localparam int DEPTH  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // line store: bit 1 top line, bit 0 middle line
  logic [1:0]        line_mem [DEPTH];
  logic [DEPTH-1:0]  line_valid;

  logic [ADDR_W-1:0] column_count;
  logic [6:0]        row_count;
  logic [7:0]        col8;
  logic              accept;
  logic              active;

  // stage 1
  logic              s1_valid;
  logic              s1_active;
  logic              s1_pixel;
  logic              s1_frame_end;
  logic              s1_eligible;
  logic              s1_first;
  logic [ADDR_W-1:0] s1_addr;
  logic [5:0]        s1_column;
  logic [5:0]        s1_row;
  logic [1:0]        s1_rd;
  logic              s1_rd_valid;

  logic [8:0]        window_bits;
  logic [8:0]        window_next;
  logic              top;
  logic              mid;

  logic [QPTR_W:0]   in_flight;

  assign in_flight  = q_count + {{QPTR_W{1'b0}}, s1_valid};
  assign item_ready = (in_flight < QUEUE_FULL);
  assign accept     = item_valid && item_ready;
  assign col8       = 8'(column_count);
  assign active     = (row_count < height);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (item.frame_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (active) begin
          if (col8 + 8'd1 >= {1'b0, width}) begin
            column_count <= '0;
            row_count    <= row_count + 7'd1;
          end else begin
            column_count <= column_count + 1'b1;
          end
        end
      end
    end
  end

  // classification and registered line store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_active    <= active;
      s1_pixel     <= item.pixel;
      s1_frame_end <= item.frame_end;
      s1_eligible  <= active && (col8 >= 8'd2) && (row_count >= 7'd2);
      s1_first     <= active && (col8 == 8'd2) && (row_count == 7'd2);
      s1_addr      <= column_count;
      s1_column    <= 6'(col8 - 8'd2);
      s1_row       <= 6'(row_count - 7'd2);
      s1_rd        <= line_mem[column_count];
      s1_rd_valid  <= line_valid[column_count];
    end
  end

  assign top = s1_rd_valid & s1_rd[1];
  assign mid = s1_rd_valid & s1_rd[0];
  assign window_next = ((window_bits >> 1) & ROW_MASK) | {6'd0, top, 2'd0}
                     | {3'd0, mid, 5'd0} | {s1_pixel, 8'd0};

  always_ff @(posedge clk) begin
    if (s1_valid && s1_active) begin
      line_mem[s1_addr] <= {mid, s1_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid  <= '0;
      window_bits <= '0;
    end else if (s1_valid) begin
      if (s1_active) begin
        line_valid[s1_addr] <= 1'b1;
      end
      if (s1_frame_end) begin
        window_bits <= '0;
      end else if (s1_active) begin
        window_bits <= window_next;
      end
    end
  end

  assign push                = s1_valid;
  assign push_data.window    = window_next;
  assign push_data.column    = s1_column;
  assign push_data.row       = s1_row;
  assign push_data.eligible  = s1_eligible;
  assign push_data.first     = s1_first;
  assign push_data.frame_end = s1_frame_end;

endmodule

[hdl/btm_back.sv]
// ----------------------------------------------------------------------------
// btm_back: match scoring back end
// Scores each window against the template, keeps the best one and
// presents the frame result in an output register.
// ----------------------------------------------------------------------------
module btm_back
  import btm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] template_bits,
  input  work_t      head,
  input  logic       not_empty,
  output logic       pop,
  output result_t    result,
  output logic       result_valid,
  input  logic       result_ready
);

  logic [3:0] best_count;
  logic [5:0] best_col_reg;
  logic [5:0] best_row_reg;
  logic [8:0] best_window_reg;

  logic [3:0] cnt;
  logic       take;
  logic [3:0] count_next;
  logic [5:0] col_next;
  logic [5:0] row_next;
  logic [8:0] window_next;

  assign pop  = not_empty && (!result_valid || result_ready);
  assign cnt  = ones9(~(head.window ^ template_bits));
  assign take = head.eligible && (head.first || (cnt > best_count));

  always_comb begin
    count_next  = take ? cnt         : best_count;
    col_next    = take ? head.column : best_col_reg;
    row_next    = take ? head.row    : best_row_reg;
    window_next = take ? head.window : best_window_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_count      <= '0;
      best_col_reg    <= '0;
      best_row_reg    <= '0;
      best_window_reg <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (pop && head.frame_end) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        if (head.frame_end) begin
          best_count      <= '0;
          best_col_reg    <= '0;
          best_row_reg    <= '0;
          best_window_reg <= '0;
        end else begin
          best_count      <= count_next;
          best_col_reg    <= col_next;
          best_row_reg    <= row_next;
          best_window_reg <= window_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.frame_end) begin
      result.match_count <= count_next;
      result.best_column <= col_next;
      result.best_row    <= row_next;
      result.best_window <= window_next;
    end
  end

endmodule

[hdl/binary_template_match_3x3.sv]
// ----------------------------------------------------------------------------
// binary_template_match_3x3: streaming 3x3 binary template matcher
// Finds the window of a binary raster image that best matches a 3x3
// template and reports it once per frame.
// ----------------------------------------------------------------------------
// Pixels arrive one per request in raster order; the request flagged
// frame_end closes the frame and yields one result: the highest count of
// window pixels equal to the template, the top-left corner of the first
// window reaching it, and that window's bits. The block takes one pixel
// per clock cycle while the work queue has room; a frame_end pixel passes
// through the stage 1 register (line store read at acceptance), then the
// work queue (window update and queue push), then the scoring into the
// output register, and a result waiting in the output register does not
// hold up input until the four-entry work queue fills. Width is clamped
// to 3..MAX_WIDTH (and 127), height to 3..64. Line store entries not yet
// written since reset read as zero through per-column valid bits, so no
// clearing pass is needed. Configuration writes are always ready and
// take effect at once.
// ----------------------------------------------------------------------------
module binary_template_match_3x3
  import btm_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  // pixel channel
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_ready,
  // result channel
  output result_t    result,
  output logic       result_valid,
  input  logic       result_ready,
  // configuration write channel
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       cfg_valid,
  output logic       cfg_ready
);

  localparam int         EFF_MAX  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam logic [6:0] EFF_MAX7 = 7'(EFF_MAX);

  // configuration registers
  logic [8:0] template_bits;
  logic [6:0] image_width;
  logic [6:0] image_height;

  // clamped sizes
  logic [6:0] width;
  logic [6:0] height;

  // front to queue to back
  logic            push;
  work_t           push_data;
  logic            pop;
  work_t           head;
  logic            not_empty;
  logic [QPTR_W:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      template_bits <= TEMPLATE_RESET;
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMPLATE: template_bits <= cfg_data;
        CFG_WIDTH:    image_width   <= cfg_data[6:0];
        CFG_HEIGHT:   image_height  <= cfg_data[6:0];
        default:      ;  // unused index, write ignored
      endcase
    end
  end

  // clamp sizes into the supported range
  always_comb begin
    if (image_width < MIN_SIZE) begin
      width = MIN_SIZE;
    end else if (image_width > EFF_MAX7) begin
      width = EFF_MAX7;
    end else begin
      width = image_width;
    end
    if (image_height < MIN_SIZE) begin
      height = MIN_SIZE;
    end else if (image_height > MAX_HEIGHT) begin
      height = MAX_HEIGHT;
    end else begin
      height = image_height;
    end
  end

  // front: counters, line stores, window, classification
  btm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .width      (width),
    .height     (height),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .q_count    (q_count),
    .push       (push),
    .push_data  (push_data)
  );

  // work queue decouples the two halves
  btm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (q_count)
  );

  // back: scoring, best tracking, result register
  btm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .template_bits (template_bits),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .result        (result),
    .result_valid  (result_valid),
    .result_ready  (result_ready)
  );

  // queue never overflows: credit check covers the front's in-flight pixel
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (q_count == QUEUE_FULL)))
    else $error("work queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("work queue underflow");

  // a shown result never scores above nine
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.match_count <= 4'd9))
    else $error("match count out of range");

  // a frame-end pixel taken by the back leads to a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && head.frame_end) |=> result_valid)
    else $error("frame end without result");

endmodule
